@@ rtl/dwc_pkg.sv @@
package dwc_pkg;

  localparam int LANES  = 4;
  localparam int DATA_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;

  typedef logic signed [DATA_W-1:0] lane_t;
  typedef lane_t [LANES-1:0] pix_t;

  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_BIAS   = 2'd1,
    MODE_PIXEL  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_IMG_WIDTH   = 3'd0,
    REG_IMG_HEIGHT  = 3'd1,
    REG_KERNEL_ROWS = 3'd2,
    REG_KERNEL_COLS = 3'd3,
    REG_STEP_ROWS   = 3'd4,
    REG_STEP_COLS   = 3'd5,
    REG_SPREAD_ROWS = 3'd6,
    REG_SPREAD_COLS = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WALK  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  // Clamped, in-range configuration.
  typedef struct packed {
    logic [8:0]  width;
    logic [12:0] height;
    logic [2:0]  krows;
    logic [2:0]  kcols;
    logic [2:0]  srows;
    logic [2:0]  scols;
    logic [1:0]  drows;
    logic [1:0]  dcols;
  } cfg_t;

  typedef struct packed {
    logic load;  // preset accumulators with bias
    logic en;    // operand pair valid this cycle
  } mac_ctl_t;

  // Floor divide by a stride of 1..4; by three through a reciprocal.
  function automatic logic [11:0] div_stride(input logic [11:0] x, input logic [2:0] d);
    logic [23:0] p;
    p = 24'(x) * 24'd2731;
    case (d)
      3'd2:    div_stride = x >> 1;
      3'd3:    div_stride = 12'(p >> 13);
      3'd4:    div_stride = x >> 2;
      default: div_stride = x;
    endcase
  endfunction

  // Round half up from Q24.16 to Q8.8, then saturate.
  function automatic lane_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] x;
    logic signed [ACC_W-8:0] q;
    x = (ACC_W+1)'(acc) + 41'sd128;
    q = (ACC_W-7)'(x >>> 8);
    if (q > 33'sd32767) begin
      round_sat = 16'sh7FFF;
    end else if (q < -33'sd32768) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = q[15:0];
    end
  endfunction

endpackage

@@ rtl/dwc_ifs.sv @@
interface dwc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  tap_index;
  logic signed [15:0] in_lane0;
  logic signed [15:0] in_lane1;
  logic signed [15:0] in_lane2;
  logic signed [15:0] in_lane3;
  modport source(output valid, mode, tap_index, in_lane0, in_lane1, in_lane2, in_lane3,
                 input ready);
  modport sink(input valid, mode, tap_index, in_lane0, in_lane1, in_lane2, in_lane3,
               output ready);
endinterface

interface dwc_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] out_lane0;
  logic signed [15:0] out_lane1;
  logic signed [15:0] out_lane2;
  logic signed [15:0] out_lane3;
  logic [11:0] out_row;
  logic [7:0]  out_col;
  logic        out_last;
  modport source(output valid, out_lane0, out_lane1, out_lane2, out_lane3, out_row, out_col,
                 out_last, input ready);
  modport sink(input valid, out_lane0, out_lane1, out_lane2, out_lane3, out_row, out_col,
               out_last, output ready);
endinterface

interface dwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/dwc_cfg.sv @@
module dwc_cfg #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dwc_cfg_if.sink       cfg_i,
  output dwc_pkg::cfg_t cfg_o
);

  localparam int WMAX = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int KMAX = (MAX_KERNEL < 7) ? MAX_KERNEL : 7;

  logic [8:0]  width_q;
  logic [12:0] height_q;
  logic [2:0]  krows_q, kcols_q, srows_q, scols_q;
  logic [1:0]  drows_q, dcols_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 13'd256;
      krows_q  <= 3'd3;
      kcols_q  <= 3'd3;
      srows_q  <= 3'd1;
      scols_q  <= 3'd1;
      drows_q  <= 2'd1;
      dcols_q  <= 2'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dwc_pkg::REG_IMG_WIDTH:   width_q  <= cfg_i.data[8:0];
        dwc_pkg::REG_IMG_HEIGHT:  height_q <= cfg_i.data;
        dwc_pkg::REG_KERNEL_ROWS: krows_q  <= cfg_i.data[2:0];
        dwc_pkg::REG_KERNEL_COLS: kcols_q  <= cfg_i.data[2:0];
        dwc_pkg::REG_STEP_ROWS:   srows_q  <= cfg_i.data[2:0];
        dwc_pkg::REG_STEP_COLS:   scols_q  <= cfg_i.data[2:0];
        dwc_pkg::REG_SPREAD_ROWS: drows_q  <= cfg_i.data[1:0];
        dwc_pkg::REG_SPREAD_COLS: dcols_q  <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.width  = (width_q == 9'd0) ? 9'd1 :
                   ((int'(width_q) > WMAX) ? 9'(WMAX) : width_q);
    cfg_o.height = (height_q == 13'd0) ? 13'd1 :
                   ((height_q > 13'd4096) ? 13'd4096 : height_q);
    cfg_o.krows  = (krows_q == 3'd0) ? 3'd1 :
                   ((int'(krows_q) > KMAX) ? 3'(KMAX) : krows_q);
    cfg_o.kcols  = (kcols_q == 3'd0) ? 3'd1 :
                   ((int'(kcols_q) > KMAX) ? 3'(KMAX) : kcols_q);
    cfg_o.srows  = (srows_q == 3'd0) ? 3'd1 : ((srows_q > 3'd4) ? 3'd4 : srows_q);
    cfg_o.scols  = (scols_q == 3'd0) ? 3'd1 : ((scols_q > 3'd4) ? 3'd4 : scols_q);
    cfg_o.drows  = (drows_q == 2'd0) ? 2'd1 : ((drows_q > 2'd2) ? 2'd2 : drows_q);
    cfg_o.dcols  = (dcols_q == 2'd0) ? 2'd1 : ((dcols_q > 2'd2) ? 2'd2 : dcols_q);
  end

endmodule

@@ rtl/dwc_store.sv @@
module dwc_store #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 7,
  parameter int LINE_ROWS  = 16,
  localparam int WDEPTH = (MAX_KERNEL * MAX_KERNEL > 64) ? 64 : MAX_KERNEL * MAX_KERNEL,
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
  localparam int LDEPTH = LINE_ROWS * MAX_WIDTH,
  localparam int LA_W   = $clog2(LDEPTH)
) (
  input  logic              clk_i,
  input  logic              w_we_i,
  input  logic [WA_W-1:0]   w_waddr_i,
  input  dwc_pkg::pix_t     w_wdata_i,
  input  logic              w_re_i,
  input  logic [WA_W-1:0]   w_raddr_i,
  output dwc_pkg::pix_t     w_rdata_o,
  input  logic              l_we_i,
  input  logic              l_re_i,
  input  logic [LA_W-1:0]   l_addr_i,
  input  dwc_pkg::pix_t     l_wdata_i,
  output dwc_pkg::pix_t     l_rdata_o
);

  dwc_pkg::pix_t wmem [WDEPTH];
  dwc_pkg::pix_t lmem [LDEPTH];

  always_ff @(posedge clk_i) begin
    if (w_we_i) begin
      wmem[w_waddr_i] <= w_wdata_i;
    end
    if (w_re_i) begin
      w_rdata_o <= wmem[w_raddr_i];
    end
  end

  // Single port: one write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (l_we_i) begin
      lmem[l_addr_i] <= l_wdata_i;
    end else if (l_re_i) begin
      l_rdata_o <= lmem[l_addr_i];
    end
  end

endmodule

@@ rtl/dwc_mac.sv @@
module dwc_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dwc_pkg::mac_ctl_t ctl_i,
  input  dwc_pkg::pix_t     bias_i,
  input  dwc_pkg::pix_t     pix_i,
  input  dwc_pkg::pix_t     wgt_i,
  output logic              busy_o,
  output dwc_pkg::pix_t     res_o
);

  logic signed [dwc_pkg::PROD_W-1:0] prod_q [dwc_pkg::LANES];
  logic signed [dwc_pkg::ACC_W-1:0]  acc_q  [dwc_pkg::LANES];
  logic prod_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < dwc_pkg::LANES; l++) begin
      if (ctl_i.en) begin
        prod_q[l] <= $signed(pix_i[l]) * $signed(wgt_i[l]);
      end
      if (ctl_i.load) begin
        acc_q[l] <= dwc_pkg::ACC_W'($signed(bias_i[l])) <<< 8;
      end else if (prod_v_q) begin
        acc_q[l] <= acc_q[l] + dwc_pkg::ACC_W'(prod_q[l]);
      end
    end
  end

  assign busy_o = prod_v_q;

  always_comb begin
    for (int l = 0; l < dwc_pkg::LANES; l++) begin
      res_o[l] = dwc_pkg::round_sat(acc_q[l]);
    end
  end

endmodule

@@ rtl/depthwise_conv2d_4lane_unit.sv @@
// Result: a pixel that closes a window starts a walk over its taps, then a drain of the MAC;
// the result then goes into the output register. Loads and other pixels give no result.
// Throughput: one window tap of four lanes per cycle, read from the single-port line
// memory and the weight memory; no new item is accepted until the window's result has
// been loaded into the output register.
// Reset: counters, phases, bias and config go to their defaults; memories are not cleared.
module depthwise_conv2d_4lane_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 7,
  parameter int LINE_ROWS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dwc_in_if.sink    in_i,
  dwc_cfg_if.sink   cfg_i,
  dwc_out_if.source out_o
);

  localparam int RS_W   = $clog2(LINE_ROWS);
  localparam int WDEPTH = (MAX_KERNEL * MAX_KERNEL > 64) ? 64 : MAX_KERNEL * MAX_KERNEL;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int LA_W   = $clog2(LINE_ROWS * MAX_WIDTH);

  dwc_pkg::cfg_t cfg;

  dwc_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  // ---------------------------------------------------------------
  // Stream position state
  // ---------------------------------------------------------------
  logic [11:0]     row_q;
  logic [7:0]      col_q;
  logic [1:0]      rph_q, cph_q;
  logic [RS_W-1:0] slot_q;    // row_q modulo LINE_ROWS
  dwc_pkg::pix_t   bias_q;

  dwc_pkg::state_e state_q, state_d;

  logic in_rdy, in_acc, is_pixel, fire, rd_en, out_load;
  logic [3:0] rspan, cspan;
  dwc_pkg::pix_t in_pix;

  assign in_pix   = {in_i.in_lane3, in_i.in_lane2, in_i.in_lane1, in_i.in_lane0};
  assign in_acc   = in_i.valid & in_rdy;
  assign is_pixel = (in_i.mode == dwc_pkg::MODE_PIXEL);
  assign rspan    = 4'(cfg.drows) * (4'(cfg.krows) - 4'd1);
  assign cspan    = 4'(cfg.dcols) * (4'(cfg.kcols) - 4'd1);
  assign fire     = (row_q >= 12'(rspan)) && (col_q >= 8'(cspan)) &&
                    (rph_q == 2'd0) && (cph_q == 2'd0);

  logic [2:0] cph_inc, rph_inc;
  assign cph_inc = {1'b0, cph_q} + 3'd1;
  assign rph_inc = {1'b0, rph_q} + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      rph_q  <= '0;
      cph_q  <= '0;
      slot_q <= '0;
      bias_q <= '0;
    end else if (in_acc) begin
      if (in_i.mode == dwc_pkg::MODE_BIAS) begin
        bias_q <= in_pix;
      end
      if (is_pixel) begin
        if (col_q >= 8'(cspan)) begin
          cph_q <= (cph_inc >= cfg.scols) ? 2'd0 : cph_inc[1:0];
        end
        if (9'(col_q) + 9'd1 >= cfg.width) begin
          col_q <= '0;
          cph_q <= '0;
          if (row_q >= 12'(rspan)) begin
            rph_q <= (rph_inc >= cfg.srows) ? 2'd0 : rph_inc[1:0];
          end
          if (13'(row_q) + 13'd1 >= cfg.height) begin
            row_q  <= '0;
            rph_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + 12'd1;
            slot_q <= (int'(slot_q) == LINE_ROWS - 1) ? '0 : slot_q + RS_W'(1);
          end
        end else begin
          col_q <= col_q + 8'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Window walk: taps visited bottom-right first, one per cycle
  // ---------------------------------------------------------------
  logic [RS_W-1:0] rptr_q;
  logic [7:0]      cptr_q, cbase_q;
  logic [5:0]      tap_q;
  logic [2:0]      kx_q, ky_q;
  logic [11:0]     orow_q;
  logic [7:0]      ocol_q;
  logic            olast_q;
  logic            rd_v_q;
  logic [RS_W:0]   rp_ext;

  assign rp_ext = {1'b0, rptr_q};

  always_ff @(posedge clk_i) begin
    if (in_acc && is_pixel && fire) begin
      rptr_q  <= slot_q;
      cptr_q  <= col_q;
      cbase_q <= col_q;
      tap_q   <= 6'(6'(cfg.krows) * 6'(cfg.kcols) - 6'd1);
      kx_q    <= cfg.kcols - 3'd1;
      ky_q    <= cfg.krows - 3'd1;
      orow_q  <= dwc_pkg::div_stride(row_q - 12'(rspan), cfg.srows);
      ocol_q  <= 8'(dwc_pkg::div_stride(12'(col_q - 8'(cspan)), cfg.scols));
      olast_q <= (13'(row_q) + 13'(cfg.srows) >= cfg.height) &&
                 (9'(col_q) + 9'(cfg.scols) >= cfg.width);
    end else if (rd_en) begin
      tap_q <= tap_q - 6'd1;
      if (kx_q == 3'd0) begin
        ky_q   <= ky_q - 3'd1;
        kx_q   <= cfg.kcols - 3'd1;
        cptr_q <= cbase_q;
        if (rp_ext >= (RS_W+1)'(cfg.drows)) begin
          rptr_q <= RS_W'(rp_ext - (RS_W+1)'(cfg.drows));
        end else begin
          rptr_q <= RS_W'(rp_ext + (RS_W+1)'(LINE_ROWS) - (RS_W+1)'(cfg.drows));
        end
      end else begin
        kx_q   <= kx_q - 3'd1;
        cptr_q <= cptr_q - 8'(cfg.dcols);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= rd_en;
    end
  end

  // ---------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------
  logic            w_we, l_we;
  logic [LA_W-1:0] l_addr;
  dwc_pkg::pix_t   w_rdata, l_rdata;

  // Pixel write lands in the accept cycle; the walk reads it back later.
  assign w_we   = in_acc && (in_i.mode == dwc_pkg::MODE_WEIGHT) &&
                  (int'(in_i.tap_index) < MAX_KERNEL * MAX_KERNEL);
  assign l_we   = in_acc && is_pixel;
  assign l_addr = rd_en ? LA_W'(rptr_q) * LA_W'(MAX_WIDTH) + LA_W'(cptr_q)
                        : LA_W'(slot_q) * LA_W'(MAX_WIDTH) + LA_W'(col_q);

  dwc_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .LINE_ROWS(LINE_ROWS)) u_store (
    .clk_i    (clk_i),
    .w_we_i   (w_we),
    .w_waddr_i(WA_W'(in_i.tap_index)),
    .w_wdata_i(in_pix),
    .w_re_i   (rd_en),
    .w_raddr_i(WA_W'(tap_q)),
    .w_rdata_o(w_rdata),
    .l_we_i   (l_we),
    .l_re_i   (rd_en),
    .l_addr_i (l_addr),
    .l_wdata_i(in_pix),
    .l_rdata_o(l_rdata)
  );

  // ---------------------------------------------------------------
  // Multiply-accumulate
  // ---------------------------------------------------------------
  dwc_pkg::mac_ctl_t mac_ctl;
  dwc_pkg::pix_t     mac_res;
  logic              mac_busy;

  assign mac_ctl.load = in_acc && is_pixel && fire;
  assign mac_ctl.en   = rd_v_q;

  dwc_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .bias_i(bias_q),
    .pix_i (l_rdata),
    .wgt_i (w_rdata),
    .busy_o(mac_busy),
    .res_o (mac_res)
  );

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  logic out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dwc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dwc_pkg::ST_IDLE: begin
        if (in_acc && is_pixel && fire) state_d = dwc_pkg::ST_WALK;
      end
      dwc_pkg::ST_WALK: begin
        if (kx_q == 3'd0 && ky_q == 3'd0) state_d = dwc_pkg::ST_DRAIN;
      end
      dwc_pkg::ST_DRAIN: begin
        if (!rd_v_q && !mac_busy) state_d = dwc_pkg::ST_DONE;
      end
      dwc_pkg::ST_DONE: begin
        if (!out_v_q || out_o.ready) state_d = dwc_pkg::ST_IDLE;
      end
      default: state_d = dwc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy   = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      dwc_pkg::ST_IDLE: in_rdy = 1'b1;
      dwc_pkg::ST_WALK: rd_en  = 1'b1;
      dwc_pkg::ST_DONE: out_load = !out_v_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_i.ready = in_rdy;

  // ---------------------------------------------------------------
  // Output register: holds one result while the block takes new items
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.out_lane0 <= mac_res[0];
      out_o.out_lane1 <= mac_res[1];
      out_o.out_lane2 <= mac_res[2];
      out_o.out_lane3 <= mac_res[3];
      out_o.out_row   <= orow_q;
      out_o.out_col   <= ocol_q;
      out_o.out_last  <= olast_q;
    end
  end

  assign out_o.valid = out_v_q;

`ifndef NO_ASSERTIONS
  a_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dwc_pkg::ST_WALK && kx_q == 3'd0 && ky_q == 3'd0) |-> (tap_q == 6'd0))
    else $error("tap counter out of step with kernel walk");
  a_rd_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> $past(state_q == dwc_pkg::ST_WALK))
    else $error("read data valid without a walk issue");
  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(l_we && rd_en))
    else $error("line memory write and read in one cycle");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(slot_q) < LINE_ROWS)
    else $error("line slot beyond line buffer");
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_v_q || out_o.ready))
    else $error("result overwrites a pending transaction");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int KMAX = 7;
  localparam int NTAPS = KMAX * KMAX;
  localparam int LROWS = 16;
  localparam int LWIDTH = 256;
  localparam int SETTLE = 80;         // well past a full window walk with the largest kernel
  localparam int MAX_ERR_SHOWN = 10;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    TXN_DATA,
    TXN_CFG,
    TXN_SYNC    // hold off until every result is back, then settle
  } txn_kind_e;

  typedef struct {
    txn_kind_e          kind;
    logic [1:0]         mode;
    logic [5:0]         tap;
    dwc_pkg::pix_t      lanes;
    dwc_pkg::reg_idx_e  idx;
    logic [12:0]        data;
  } txn_t;

  typedef struct {
    dwc_pkg::pix_t lanes;
    logic [11:0]   row;
    logic [7:0]    col;
    logic          last;
  } conv_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dwc_in_if  in_if ();
  dwc_cfg_if cfg_if ();
  dwc_out_if out_if ();

  depthwise_conv2d_4lane_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .cfg_i  (cfg_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Shadow of the block: raw register values, stores, counters.
  // ------------------------------------------------------------------
  logic [12:0] shadow_reg [8];
  int          weights [NTAPS][4];
  int          bias [4];
  int          lines [LROWS*LWIDTH][4];
  int          row_cnt, col_cnt, row_ph, col_ph;

  conv_out_t   sums_due [$];
  txn_t        pending [$];

  int n_errors = 0;
  int n_pixels = 0;
  int n_results = 0;
  int n_cfg = 0;
  bit done_filling = 0;

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [15:0] sat_round(longint acc);
    longint q;
    q = (acc + 128) >>> 8;   // floor, so round half up
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Advances the shadow by one accepted data transaction; returns 1 if a
  // window closed, with its sums in res.
  function automatic bit conv_step(input txn_t t, output conv_out_t res);
    int w, h, kr, kc, sr, sc, dr, dc, rspan, cspan, r, c, rr, cc, slot;
    longint acc [4];
    bit hit;
    hit = 0;
    res = '{default: '0};
    if (t.mode == dwc_pkg::MODE_WEIGHT) begin
      if (t.tap < NTAPS)
        for (int l = 0; l < 4; l++) weights[t.tap][l] = int'(t.lanes[l]);
      return 0;
    end
    if (t.mode == dwc_pkg::MODE_BIAS) begin
      for (int l = 0; l < 4; l++) bias[l] = int'(t.lanes[l]);
      return 0;
    end
    if (t.mode != dwc_pkg::MODE_PIXEL) return 0;
    w  = clampi(int'(shadow_reg[dwc_pkg::REG_IMG_WIDTH][8:0]), 1, 256);
    h  = clampi(int'(shadow_reg[dwc_pkg::REG_IMG_HEIGHT]), 1, 4096);
    kr = clampi(int'(shadow_reg[dwc_pkg::REG_KERNEL_ROWS][2:0]), 1, KMAX);
    kc = clampi(int'(shadow_reg[dwc_pkg::REG_KERNEL_COLS][2:0]), 1, KMAX);
    sr = clampi(int'(shadow_reg[dwc_pkg::REG_STEP_ROWS][2:0]), 1, 4);
    sc = clampi(int'(shadow_reg[dwc_pkg::REG_STEP_COLS][2:0]), 1, 4);
    dr = clampi(int'(shadow_reg[dwc_pkg::REG_SPREAD_ROWS][1:0]), 1, 2);
    dc = clampi(int'(shadow_reg[dwc_pkg::REG_SPREAD_COLS][1:0]), 1, 2);
    rspan = dr * (kr - 1);
    cspan = dc * (kc - 1);
    r = row_cnt;
    c = col_cnt;
    slot = (r % LROWS) * LWIDTH + (c % LWIDTH);
    for (int l = 0; l < 4; l++) lines[slot][l] = int'(t.lanes[l]);
    if (r >= rspan && c >= cspan && row_ph == 0 && col_ph == 0) begin
      for (int l = 0; l < 4; l++) acc[l] = longint'(bias[l]) * 256;
      for (int ky = 0; ky < kr; ky++) begin
        rr = (r - rspan + ky * dr) % LROWS;
        for (int kx = 0; kx < kc; kx++) begin
          cc = (c - cspan + kx * dc) % LWIDTH;
          for (int l = 0; l < 4; l++)
            acc[l] += longint'(lines[rr*LWIDTH+cc][l]) * longint'(weights[ky*kc+kx][l]);
        end
      end
      for (int l = 0; l < 4; l++) res.lanes[l] = sat_round(acc[l]);
      res.row  = 12'((r - rspan) / sr);
      res.col  = 8'((c - cspan) / sc);
      res.last = (r + sr >= h) && (c + sc >= w);
      hit = 1;
    end
    if (c >= cspan) col_ph = (col_ph + 1 >= sc) ? 0 : col_ph + 1;
    if (c + 1 >= w) begin
      col_cnt = 0;
      col_ph = 0;
      if (r >= rspan) row_ph = (row_ph + 1 >= sr) ? 0 : row_ph + 1;
      if (r + 1 >= h) begin
        row_cnt = 0;
        row_ph = 0;
      end else begin
        row_cnt = r + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
    return hit;
  endfunction

  // Idle / stall draws; every third stretch of 64 draws has no idling, the others idle at random.
  function automatic int draw_gap(int seq);
    return ((seq / 64) % 3 == 2) ? 0 : $urandom_range(0, 11);
  endfunction

  // ------------------------------------------------------------------
  // Driver: both channels fed from one ordered queue.
  // ------------------------------------------------------------------
  int  in_gap, settle, drv_seq;
  txn_t cur;

  always @(posedge clk_i or negedge rst_ni) begin
    logic      nx_in_vld, nx_cfg_vld;
    conv_out_t res;
    txn_t      t;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.mode <= dwc_pkg::MODE_WEIGHT;
      in_if.tap_index <= '0;
      in_if.in_lane0 <= '0;
      in_if.in_lane1 <= '0;
      in_if.in_lane2 <= '0;
      in_if.in_lane3 <= '0;
      cfg_if.valid <= 1'b0;
      cfg_if.index <= dwc_pkg::REG_IMG_WIDTH;
      cfg_if.data <= '0;
      in_gap <= 0;
      settle <= 0;
      drv_seq <= 0;
    end else begin
      nx_in_vld = in_if.valid;
      nx_cfg_vld = cfg_if.valid;
      if (in_if.valid && in_if.ready) begin
        if (conv_step(cur, res)) sums_due.push_back(res);
        if (cur.mode == dwc_pkg::MODE_PIXEL) n_pixels++;
        nx_in_vld = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        shadow_reg[cur.idx] = cur.data;
        n_cfg++;
        nx_cfg_vld = 1'b0;
      end
      if (!nx_in_vld && !nx_cfg_vld) begin
        if (settle > 0) begin
          settle <= settle - 1;
        end else if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending.size() > 0) begin
          t = pending[0];
          if (t.kind == TXN_SYNC) begin
            if (sums_due.size() == 0) begin
              void'(pending.pop_front());
              settle <= SETTLE;
            end
          end else begin
            void'(pending.pop_front());
            cur = t;
            drv_seq <= drv_seq + 1;
            in_gap <= draw_gap(drv_seq);
            if (t.kind == TXN_CFG) begin
              cfg_if.index <= t.idx;
              cfg_if.data <= t.data;
              nx_cfg_vld = 1'b1;
            end else begin
              in_if.mode <= t.mode;
              in_if.tap_index <= t.tap;
              in_if.in_lane0 <= t.lanes[0];
              in_if.in_lane1 <= t.lanes[1];
              in_if.in_lane2 <= t.lanes[2];
              in_if.in_lane3 <= t.lanes[3];
              nx_in_vld = 1'b1;
            end
          end
        end
      end
      in_if.valid <= nx_in_vld;
      cfg_if.valid <= nx_cfg_vld;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: random back-pressure, in-order compare.
  // ------------------------------------------------------------------
  int stall, mon_seq;

  always @(posedge clk_i or negedge rst_ni) begin
    conv_out_t want;
    logic      nx_rdy;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall <= 0;
      mon_seq <= 0;
    end else begin
      nx_rdy = out_if.ready;
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (sums_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_ERR_SHOWN)
            $display("unexpected result row %0d col %0d", out_if.out_row, out_if.out_col);
        end else begin
          want = sums_due.pop_front();
          if (out_if.out_lane0 !== want.lanes[0] || out_if.out_lane1 !== want.lanes[1] ||
              out_if.out_lane2 !== want.lanes[2] || out_if.out_lane3 !== want.lanes[3] ||
              out_if.out_row !== want.row || out_if.out_col !== want.col ||
              out_if.out_last !== want.last) begin
            n_errors++;
            if (n_errors <= MAX_ERR_SHOWN)
              $display("mismatch: exp %h %h %h %h r%0d c%0d l%0d, got %h %h %h %h r%0d c%0d l%0d",
                       want.lanes[0], want.lanes[1], want.lanes[2], want.lanes[3],
                       want.row, want.col, want.last,
                       out_if.out_lane0, out_if.out_lane1, out_if.out_lane2,
                       out_if.out_lane3, out_if.out_row, out_if.out_col, out_if.out_last);
          end
        end
        stall <= draw_gap(mon_seq + 32);
        mon_seq <= mon_seq + 1;
        nx_rdy = 1'b0;
      end else if (!out_if.ready) begin
        if (stall > 0) stall <= stall - 1;
        else nx_rdy = 1'b1;
      end
      out_if.ready <= nx_rdy;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  function automatic logic [15:0] rnd_lane(bit wide);
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return wide ? 16'($urandom()) : 16'($signed($urandom_range(0, 1023)) - 512);
    endcase
  endfunction

  task automatic push_cfg(dwc_pkg::reg_idx_e idx, int val);
    txn_t t;
    t = '{kind: TXN_CFG, mode: dwc_pkg::MODE_WEIGHT, tap: '0, lanes: '0, idx: idx,
          data: 13'(val)};
    pending.push_back(t);
  endtask

  task automatic push_data(logic [1:0] mode, int tap, bit wide);
    txn_t t;
    t = '{kind: TXN_DATA, mode: mode, tap: 6'(tap), lanes: '0,
          idx: dwc_pkg::REG_IMG_WIDTH, data: '0};
    for (int l = 0; l < 4; l++) t.lanes[l] = rnd_lane(wide);
    pending.push_back(t);
  endtask

  task automatic push_sync();
    txn_t t;
    t = '{kind: TXN_SYNC, mode: dwc_pkg::MODE_WEIGHT, tap: '0, lanes: '0,
          idx: dwc_pkg::REG_IMG_WIDTH, data: '0};
    pending.push_back(t);
  endtask

  // One setting: a sync, registers, taps, bias, then whole images so that the
  // counters are back at zero for the next setting.
  task automatic push_phase(int w, int h, int kr, int kc, int sr, int sc, int dr, int dc,
                            int ntaps, int images, bit wide);
    int wc, hc;
    push_sync();
    push_cfg(dwc_pkg::REG_IMG_WIDTH, w);
    push_cfg(dwc_pkg::REG_IMG_HEIGHT, h);
    push_cfg(dwc_pkg::REG_KERNEL_ROWS, kr);
    push_cfg(dwc_pkg::REG_KERNEL_COLS, kc);
    push_cfg(dwc_pkg::REG_STEP_ROWS, sr);
    push_cfg(dwc_pkg::REG_STEP_COLS, sc);
    push_cfg(dwc_pkg::REG_SPREAD_ROWS, dr);
    push_cfg(dwc_pkg::REG_SPREAD_COLS, dc);
    for (int i = 0; i < ntaps; i++) push_data(dwc_pkg::MODE_WEIGHT, i, wide);
    push_data(dwc_pkg::MODE_BIAS, 0, wide);
    wc = clampi(w & 9'h1FF, 1, 256);
    hc = clampi(h, 1, 4096);
    for (int k = 0; k < images * wc * hc; k++) push_data(dwc_pkg::MODE_PIXEL, 0, wide);
  endtask

  int pix_total;

  initial begin
    for (int i = 0; i < 8; i++) shadow_reg[i] = '0;
    shadow_reg[dwc_pkg::REG_IMG_WIDTH] = 256;
    shadow_reg[dwc_pkg::REG_IMG_HEIGHT] = 256;
    shadow_reg[dwc_pkg::REG_KERNEL_ROWS] = 3;
    shadow_reg[dwc_pkg::REG_KERNEL_COLS] = 3;
    shadow_reg[dwc_pkg::REG_STEP_ROWS] = 1;
    shadow_reg[dwc_pkg::REG_STEP_COLS] = 1;
    shadow_reg[dwc_pkg::REG_SPREAD_ROWS] = 1;
    shadow_reg[dwc_pkg::REG_SPREAD_COLS] = 1;
    for (int i = 0; i < 4; i++) bias[i] = 0;
    row_cnt = 0; col_cnt = 0; row_ph = 0; col_ph = 0;

    // Directed: full-scale taps (saturation), every mode, ignored taps.
    push_phase(5, 4, 3, 3, 1, 1, 1, 1, NTAPS, 1, 1);
    push_data(MODE_UNUSED, 63, 1);                     // unused mode dropped
    push_data(dwc_pkg::MODE_WEIGHT, 63, 1);            // tap beyond store dropped
    push_data(dwc_pkg::MODE_WEIGHT, 49, 1);
    // Out-of-range register values clamp; zero and largest ones written, then replaced.
    push_sync();
    push_cfg(dwc_pkg::REG_IMG_HEIGHT, 13'h1FFF);
    push_cfg(dwc_pkg::REG_KERNEL_ROWS, 0);
    push_cfg(dwc_pkg::REG_STEP_COLS, 7);
    push_cfg(dwc_pkg::REG_SPREAD_COLS, 3);
    push_phase(300, 1, 1, 1, 0, 7, 0, 3, 0, 1, 1);   // width clamps to 256
    push_phase(16, 14, 7, 7, 2, 3, 2, 2, 0, 1, 0);   // largest, dilated kernel
    push_phase(9, 7, 2, 5, 4, 1, 2, 1, 0, 2, 1);     // two images back to back
    push_phase(3, 3, 5, 2, 1, 1, 1, 1, 0, 1, 1);     // window taller than image
    push_phase(1, 1, 1, 1, 1, 1, 1, 1, 0, 3, 1);     // single-pixel image
    push_phase(8, 6, 3, 3, 1, 1, 1, 1, 0, 1, 0);     // mostly small values, zero mean

    pix_total = 256 + 224 + 126 + 9 + 3 + 48;
    while (pix_total < 800) begin
      int w, h, kr, kc;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      kr = $urandom_range(1, 7);
      kc = $urandom_range(1, 7);
      push_phase(w, h, kr, kc, $urandom_range(1, 4), $urandom_range(1, 4),
                 $urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(0, kr*kc),
                 $urandom_range(1, 2), $urandom_range(0, 1));
      pix_total += w * h;
    end
    push_sync();
    done_filling = 1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending.size() == 0 && settle == 0 && !in_if.valid && !cfg_if.valid &&
          sums_due.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (sums_due.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", sums_due.size());
    end
    $display("covered %0d pixels, %0d window results, %0d register writes",
             n_pixels, n_results, n_cfg);
    $display("%0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d transactions queued", pending.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dwc_pkg.sv
rtl/dwc_ifs.sv
rtl/dwc_cfg.sv
rtl/dwc_store.sv
rtl/dwc_mac.sv
rtl/depthwise_conv2d_4lane_unit.sv
dv/testbench.sv
